FILE: rtl/pid_speed_controller_assert.svh
// ----------------------------------------------------------------------------
// pid_speed_controller assertion macros
// Short forms for the concurrent checks of the speed controller
// ----------------------------------------------------------------------------
`ifndef PID_SPEED_CONTROLLER_ASSERT_SVH
`define PID_SPEED_CONTROLLER_ASSERT_SVH

// check that is switched off while reset is held
`define PIDSC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that also runs during reset
`define PIDSC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/pidsc_pkg.sv
// ----------------------------------------------------------------------------
// pidsc_pkg
// Types and constants shared by the speed controller modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pidsc_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_GAIN_P     = 2'd0;
  localparam logic [1:0] CFG_GAIN_I     = 2'd1;
  localparam logic [1:0] CFG_GAIN_D     = 2'd2;
  localparam logic [1:0] CFG_CYCLE_TIME = 2'd3;

  // datapath widths
  localparam int GAIN_W  = 24;
  localparam int OPND_W  = 28;  // multiplier operand, sign extended
  localparam int ACC_W   = 62;  // exact Q.24 sum of the three terms
  localparam int DIGIT_W = 4;
  localparam int DIGITS  = OPND_W / DIGIT_W;
  localparam int DIV_W   = 25;  // |error difference| * 256
  localparam int INTEG_W = 27;
  localparam int ERR_W   = 17;

  // integral clamp bound
  localparam logic signed [INTEG_W-1:0] INTEG_LIMIT = 27'sd100;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_MAC_P,
    S_MAC_I,
    S_MAC_D,
    S_FIN
  } state_t;

  // control from the sequencer to the digit-serial multiply-accumulate
  typedef struct packed {
    logic clear;
    logic start;
    logic scale;  // shift the gain up by 8 bits
  } mac_ctrl_t;

endpackage

FILE: rtl/pidsc_mac.sv
// ----------------------------------------------------------------------------
// pidsc_mac
// Digit-serial signed multiply-accumulate, four operand bits per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pidsc_mac (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  pidsc_pkg::mac_ctrl_t                   ctrl,
  input  logic signed [pidsc_pkg::GAIN_W-1:0]    gain,
  input  logic signed [pidsc_pkg::OPND_W-1:0]    operand,
  output logic                                   busy,
  output logic signed [pidsc_pkg::ACC_W-1:0]     acc
);
  import pidsc_pkg::*;

  localparam int CNT_W = $clog2(DIGITS);

  logic signed [ACC_W-1:0]  mcand_r, mcand_nxt;
  logic [OPND_W-1:0]        mplier_r, mplier_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     busy_r, busy_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic                     last_digit;
  logic signed [DIGIT_W:0]  digit_s;
  logic signed [ACC_W-1:0]  partial;

  // top digit carries the negative weight of the operand sign
  assign last_digit = (cnt_r == CNT_W'(DIGITS - 1));
  assign digit_s    = {last_digit & mplier_r[DIGIT_W-1], mplier_r[DIGIT_W-1:0]};
  assign partial    = mcand_r * ACC_W'(digit_s);

  // digit step and operand load
  always_comb begin
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    cnt_nxt    = cnt_r;
    busy_nxt   = busy_r;
    acc_nxt    = acc_r;
    if (ctrl.clear) begin
      acc_nxt = '0;
    end
    if (ctrl.start) begin
      mcand_nxt  = ctrl.scale ? (ACC_W'(gain) <<< 8) : ACC_W'(gain);
      mplier_nxt = operand;
      cnt_nxt    = '0;
      busy_nxt   = 1'b1;
    end else if (busy_r) begin
      acc_nxt    = acc_r + partial;
      mcand_nxt  = mcand_r <<< DIGIT_W;
      mplier_nxt = mplier_r >> DIGIT_W;
      cnt_nxt    = cnt_r + CNT_W'(1);
      busy_nxt   = !last_digit;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // operand and accumulator registers
  always_ff @(posedge clk) begin
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    acc_r    <= acc_nxt;
  end

  assign busy = busy_r;
  assign acc  = acc_r;

endmodule

FILE: rtl/pidsc_div.sv
// ----------------------------------------------------------------------------
// pidsc_div
// Bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pidsc_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [pidsc_pkg::DIV_W-1:0]    dividend,
  input  logic [7:0]                     divisor,
  output logic                           busy,
  output logic [pidsc_pkg::DIV_W-1:0]    quotient
);
  import pidsc_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [7:0]       rem_r, rem_nxt;
  logic [7:0]       dsor_r, dsor_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [8:0]       rem_sh;
  logic             fits;
  logic [8:0]       rem_sub;

  // trial subtract of the shifted remainder
  assign rem_sh  = {rem_r, quo_r[DIV_W-1]};
  assign fits    = (rem_sh >= {1'b0, dsor_r});
  assign rem_sub = rem_sh - {1'b0, dsor_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsor_nxt = dsor_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsor_nxt = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt  = {quo_r[DIV_W-2:0], fits};
      rem_nxt  = fits ? rem_sub[7:0] : rem_sh[7:0];
      cnt_nxt  = cnt_r + CNT_W'(1);
      busy_nxt = (cnt_r != CNT_W'(DIV_W - 1));
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // shift registers
  always_ff @(posedge clk) begin
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    dsor_r <= dsor_nxt;
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

FILE: rtl/pid_speed_controller.sv
// Each input item is worked through before the next one is taken, and a
// zero target skips the arithmetic. The time per item is set by the 25-step
// bit-serial derivative divider followed by the digit-serial
// multiply-accumulate for the derivative term.
// Reset (rst_n low, synchronous) clears gains to 0, cycle time to 1,
// the integral and last error to 0, and empties the output register.
// ----------------------------------------------------------------------------
// pid_speed_controller
// PID speed loop with clamped integral, digit-serial multiply and bit-serial divide
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pid_speed_controller (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] target_value, [31:16] measured_value
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] drive
  // configuration
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_addr,
  input  logic [23:0] cfg_wdata
);
  import pidsc_pkg::*;

  state_t state_r, state_nxt;

  // configuration registers
  logic signed [GAIN_W-1:0] gain_p_r, gain_i_r, gain_d_r;
  logic [7:0]               cycle_time_r;
  logic [7:0]               cyc_eff;

  // controller state and captured inputs
  logic signed [INTEG_W-1:0] integral_r;
  logic signed [ERR_W-1:0]   last_err_r;
  logic signed [15:0]        target_r, measured_r;
  logic                      dneg_r;

  // output register
  logic        out_valid_r;
  logic [31:0] out_data_r;

  // datapath
  logic                      in_xfer, in_zero, out_free;
  logic signed [ERR_W-1:0]   err_s;
  logic signed [INTEG_W-1:0] integ_clamp;
  logic signed [25:0]        err_cyc;
  logic signed [INTEG_W-1:0] integ_new;
  logic signed [ERR_W:0]     diff_s;
  logic [ERR_W:0]            diff_mag;
  logic [DIV_W-1:0]          dividend;
  logic [DIV_W-1:0]          quotient;
  logic signed [DIV_W:0]     deriv;
  logic                      div_busy, div_start;
  mac_ctrl_t                 mac_ctrl;
  logic signed [GAIN_W-1:0]  mac_gain;
  logic signed [OPND_W-1:0]  mac_opnd;
  logic                      mac_busy;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-17:0]  acc_sh;
  logic                      ovf;
  logic [31:0]               drive_sat;

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign in_zero   = (in_tdata[15:0] == 16'd0);
  assign out_free  = !out_valid_r || out_tready;
  assign cyc_eff   = (cycle_time_r == 8'd0) ? 8'd1 : cycle_time_r;

  // error, clamped integral update and derivative dividend
  assign err_s       = ERR_W'(target_r) - ERR_W'(measured_r);
  assign integ_clamp = (integral_r > INTEG_LIMIT)  ? INTEG_LIMIT :
                       (integral_r < -INTEG_LIMIT) ? -INTEG_LIMIT : integral_r;
  assign err_cyc     = err_s * $signed({1'b0, cyc_eff});
  assign integ_new   = integ_clamp + INTEG_W'(err_cyc);
  assign diff_s      = (ERR_W + 1)'(err_s) - (ERR_W + 1)'(last_err_r);
  assign diff_mag    = diff_s[ERR_W] ? (ERR_W + 1)'(-diff_s) : diff_s;
  assign dividend    = {diff_mag[ERR_W-1:0], 8'd0};
  assign deriv       = dneg_r ? -$signed({1'b0, quotient}) : $signed({1'b0, quotient});

  // floor shift by 16 and saturation to the drive range
  assign acc_sh    = acc[ACC_W-1:16];
  assign ovf       = !((&acc_sh[ACC_W-17:31]) || !(|acc_sh[ACC_W-17:31]));
  assign drive_sat = !ovf ? acc_sh[31:0] :
                     acc_sh[ACC_W-17] ? 32'h8000_0000 : 32'h7fff_ffff;

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    mac_ctrl       = '0;
    div_start      = 1'b0;
    mac_gain       = gain_p_r;
    mac_opnd       = OPND_W'(err_s);
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          mac_ctrl.clear = 1'b1;
          state_nxt      = in_zero ? S_FIN : S_PREP;
        end
      end
      S_PREP: begin
        div_start      = 1'b1;
        mac_ctrl.start = 1'b1;
        mac_ctrl.scale = 1'b1;
        state_nxt      = S_MAC_P;
      end
      S_MAC_P: begin
        mac_gain = gain_i_r;
        mac_opnd = OPND_W'(integral_r);
        if (!mac_busy) begin
          mac_ctrl.start = 1'b1;
          mac_ctrl.scale = 1'b1;
          state_nxt      = S_MAC_I;
        end
      end
      S_MAC_I: begin
        mac_gain = gain_d_r;
        mac_opnd = OPND_W'(deriv);
        if (!mac_busy && !div_busy) begin
          mac_ctrl.start = 1'b1;
          state_nxt      = S_MAC_D;
        end
      end
      S_MAC_D: begin
        if (!mac_busy) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r     <= '0;
      gain_i_r     <= '0;
      gain_d_r     <= '0;
      cycle_time_r <= 8'd1;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_GAIN_P:     gain_p_r     <= cfg_wdata;
        CFG_GAIN_I:     gain_i_r     <= cfg_wdata;
        CFG_GAIN_D:     gain_d_r     <= cfg_wdata;
        CFG_CYCLE_TIME: cycle_time_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // integral and last error
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integral_r <= '0;
      last_err_r <= '0;
    end else if (in_xfer && in_zero) begin
      integral_r <= '0;
      last_err_r <= '0;
    end else if (state_r == S_PREP) begin
      integral_r <= integ_new;
      last_err_r <= err_s;
    end
  end

  // captured input and derivative sign
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      target_r   <= in_tdata[15:0];
      measured_r <= in_tdata[31:16];
    end
    if (state_r == S_PREP) begin
      dneg_r <= diff_s[ERR_W];
    end
  end

  // result register, free to take the next transfer as soon as it is read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_FIN && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FIN && out_free) begin
      out_data_r <= drive_sat;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  pidsc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (cyc_eff),
    .busy     (div_busy),
    .quotient (quotient)
  );

  pidsc_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (mac_ctrl),
    .gain    (mac_gain),
    .operand (mac_opnd),
    .busy    (mac_busy),
    .acc     (acc)
  );

endmodule

FILE: rtl/pidsc_checker.sv
// ----------------------------------------------------------------------------
// pidsc_checker
// Port-level checks of the speed controller, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pid_speed_controller_assert.svh"

module pidsc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  // a waiting result holds still
  `PIDSC_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result changed while stalled")

  // one item at a time: ready drops after an input transfer
  `PIDSC_ASSERT(a_one_item, clk, rst_n, in_tvalid && in_tready |=> !in_tready, "second item taken while busy")

  // a new result only comes from work in progress
  `PIDSC_ASSERT(a_result_source, clk, rst_n, $rose(out_tvalid) |-> $past(!in_tready), "result appeared while idle")

  // reset empties the output register
  `PIDSC_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind pid_speed_controller pidsc_checker u_pidsc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: tb/pid_speed_controller_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_speed_controller_tb
// Self-checking bench for the PID speed controller. A scoreboard class keeps
// its own copy of the gains, the cycle time, the integral and the last error,
// predicts the drive of every input transfer and checks each drive transfer
// in order. Directed ticks cover the field extremes, zero targets, a zero
// cycle time and saturation; random phases follow, each with new settings.
// ----------------------------------------------------------------------------

module pid_speed_controller_tb;
  import pidsc_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_TICKS   = 1600;
  localparam int SETTLE_CYCLES  = 48;

  // drive prediction and in-order checking
  class drive_scoreboard;
    localparam longint DRIVE_MAX = 64'sd2147483647;
    localparam longint DRIVE_MIN = -64'sd2147483648;

    longint      kp, ki, kd;
    int unsigned ticks;
    longint      integ, prev_err;
    logic [31:0] drive_q[$];
    int unsigned errors;

    function new();
      kp = 0;
      ki = 0;
      kd = 0;
      ticks = 1;
      integ = 0;
      prev_err = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] addr, logic [23:0] val);
      case (addr)
        CFG_GAIN_P:     kp = longint'($signed(val));
        CFG_GAIN_I:     ki = longint'($signed(val));
        CFG_GAIN_D:     kd = longint'($signed(val));
        CFG_CYCLE_TIME: ticks = 32'(val[7:0]);
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return drive_q.size();
    endfunction

    // one control tick at input transfer
    function void note_tick(logic [15:0] tgt, logic [15:0] meas);
      longint err, deriv, acc, drv, period;
      // zero target clears the loop state
      if (tgt == 16'd0) begin
        integ = 0;
        prev_err = 0;
        drive_q.push_back(32'd0);
        return;
      end
      // a cycle time of zero behaves as one
      period = (ticks == 0) ? 64'sd1 : longint'(ticks);
      // clamp the stored integral before use
      if (integ > longint'(INTEG_LIMIT))
        integ = longint'(INTEG_LIMIT);
      else if (integ < -longint'(INTEG_LIMIT))
        integ = -longint'(INTEG_LIMIT);
      err = longint'($signed(tgt)) - longint'($signed(meas));
      integ += err * period;
      // derivative in Q.8, truncated toward zero
      deriv = ((err - prev_err) * 256) / period;
      prev_err = err;
      // exact Q.24 sum, floor to Q.8, then saturate
      acc = kp * err * 256 + ki * integ * 256 + kd * deriv;
      drv = acc >>> 16;
      if (drv > DRIVE_MAX)
        drv = DRIVE_MAX;
      else if (drv < DRIVE_MIN)
        drv = DRIVE_MIN;
      drive_q.push_back(drv[31:0]);
    endfunction

    // one drive transfer
    function void check_drive(logic [31:0] got);
      logic [31:0] want;
      if (drive_q.size() == 0) begin
        $error("drive: expected none, actual %0d", $signed(got));
        errors++;
        return;
      end
      want = drive_q.pop_front();
      if (got !== want) begin
        $error("drive: expected %0d, actual %0d", $signed(want), $signed(got));
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // [15:0] target_value, [31:16] measured_value
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // [31:0] drive
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_addr = CFG_GAIN_P;
  logic [23:0] cfg_wdata = '0;

  drive_scoreboard sb;
  bit calm = 1'b0;
  int unsigned idle_cycles = 0;

  pid_speed_controller u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // result side: check each drive transfer, stall at random
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_drive(out_tdata);
    out_tready <= calm || ($urandom_range(0, 99) >= 12);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // one input transfer, with random gaps ahead of it
  task automatic send_tick(input logic [15:0] tgt, input logic [15:0] meas);
    while (!calm && $urandom_range(0, 99) < 12) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {meas, tgt};
    do @(posedge clk); while (!in_tready);
    sb.note_tick(tgt, meas);
  endtask

  // hold the sender until every drive has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] addr, input logic [23:0] val);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(addr, val);
  endtask

  // write all four registers; unused cycle time bits carry noise
  task automatic load_config(input logic [23:0] kp, input logic [23:0] ki,
                             input logic [23:0] kd, input logic [7:0] ct);
    write_reg(CFG_GAIN_P, kp);
    write_reg(CFG_GAIN_I, ki);
    write_reg(CFG_GAIN_D, kd);
    write_reg(CFG_CYCLE_TIME, {16'($urandom), ct});
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [23:0] rand_gain();
    case ($urandom_range(0, 9))
      0:          return 24'h7FFFFF;
      1:          return 24'h800000;
      2, 3, 4, 5: return 24'($urandom_range(0, 1 << 19) - (1 << 18));
      default:    return 24'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] rand_period();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [15:0] rand_count();
    case ($urandom_range(0, 9))
      0:          return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
      1, 2, 3, 4: return 16'($urandom_range(0, 600) - 300);
      default:    return 16'($urandom);
    endcase
  endfunction

  // stimulus
  initial begin
    int unsigned sent;
    int unsigned phase;
    int unsigned n;
    bit          tracking;
    logic [15:0] tgt;
    logic [15:0] meas;

    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // gains at reset value: drive stays zero
    send_tick(16'd100, 16'd50);
    send_tick(16'd0, 16'd7);
    send_tick(16'hFFFB, 16'd20);
    drain();

    // unit, half and quarter gains, field extremes and a zero target mid-stream
    load_config(24'h010000, 24'h008000, 24'h004000, 8'd1);
    send_tick(16'h7FFF, 16'h8000);
    send_tick(16'h8000, 16'h7FFF);
    send_tick(16'h7FFF, 16'h8000);
    send_tick(16'h0000, 16'h8000);
    send_tick(16'h0001, 16'h0000);
    send_tick(16'hFFFF, 16'h0000);
    send_tick(16'h8000, 16'h8000);
    send_tick(16'h7FFF, 16'h7FFF);
    drain();

    // zero cycle time
    load_config(24'(-65536), 24'd100, 24'(-3), 8'd0);
    send_tick(16'd1000, 16'(-1000));
    send_tick(16'(-1000), 16'd1000);
    send_tick(16'd5, 16'd5);
    send_tick(16'd0, 16'd0);
    drain();

    // drive saturation at both limits, longest cycle time
    load_config(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 8'd255);
    send_tick(16'h7FFF, 16'h8000);
    send_tick(16'h7FFF, 16'h8000);
    send_tick(16'h8000, 16'h7FFF);
    drain();
    load_config(24'h800000, 24'h800000, 24'h800000, 8'd255);
    send_tick(16'h8000, 16'h7FFF);
    send_tick(16'h7FFF, 16'h8000);
    drain();

    // random phases, one long stretch without idling
    sent = 0;
    phase = 0;
    while (sent < RANDOM_TICKS) begin
      calm = (phase == 2);
      load_config(rand_gain(), rand_gain(), rand_gain(), rand_period());
      n = calm ? 300 : $urandom_range(20, 150);
      tracking = ($urandom_range(0, 9) < 6);
      tgt = rand_count();
      repeat (n) begin
        if (tracking) begin
          // measured value settles around a mostly steady target
          if ($urandom_range(0, 19) == 0)
            tgt = rand_count();
          meas = tgt + 16'($urandom_range(0, 40) - 20);
        end else begin
          tgt  = rand_count();
          meas = rand_count();
        end
        send_tick(($urandom_range(0, 24) == 0) ? 16'd0 : tgt, meas);
        sent++;
      end
      drain();
      calm = 1'b0;
      phase++;
    end

    // settle and report
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
